FILE: src/sfr_pkg.sv
package sfr_pkg;

  // frame buffer geometry
  localparam int BUF_DEPTH = 64;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int BANK_N    = 2;
  localparam int MEM_AW    = ADDR_W + 1;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 6;
  localparam int LEN_W   = 6;
  localparam int ENT_W   = 2;
  localparam int ENTRY_N = 3;
  localparam int CMP_W   = (CNT_W > LEN_W + 1) ? CNT_W : LEN_W + 1;

  // framing bytes
  localparam logic [BYTE_W-1:0] HEAD_BYTE = 8'hFD;
  localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'hF8;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'hFE;
  localparam logic [BYTE_W-1:0] ESC_HEAD  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_TAIL  = 8'h78;
  localparam logic [BYTE_W-1:0] ESC_ESC   = 8'h7E;

  // head, type, serial, sum and tail around the payload
  localparam int FRAME_OVERHEAD = 5;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_E0_TYPE = 3'd0,
    REG_E0_LEN  = 3'd1,
    REG_E1_TYPE = 3'd2,
    REG_E1_LEN  = 3'd3,
    REG_E2_TYPE = 3'd4,
    REG_E2_LEN  = 3'd5,
    REG_SUM_EN  = 3'd6
  } reg_idx_e;

  // buffer write port driven by the front end
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

  // one accepted frame waiting for emission
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] len;
    logic [ENT_W-1:0] entry;
  } frame_desc_t;

  // map an escaped code back to the original byte
  function automatic logic [BYTE_W-1:0] unescape(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    case (b)
      ESC_HEAD: r = HEAD_BYTE;
      ESC_TAIL: r = TAIL_BYTE;
      ESC_ESC:  r = ESC_BYTE;
      default:  r = b;
    endcase
    return r;
  endfunction

endpackage

FILE: src/sfr_front.sv
module sfr_front
  import sfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [BYTE_W-1:0]   s_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [BYTE_W-1:0]   cfg_data_i,
  input  logic                release_i,
  output mem_wr_t             mem_wr_o,
  output logic                push_o,
  output frame_desc_t         desc_o
);

  // configuration
  logic [BYTE_W-1:0] entry_type_q [ENTRY_N];
  logic [LEN_W-1:0]  entry_len_q  [ENTRY_N];
  logic              sum_en_q;

  // receive state
  logic              in_frame_q, in_frame_d;
  logic              esc_q, esc_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] prev_q, prev_d;
  logic [BYTE_W-1:0] type_q, type_d;
  logic              bank_q, bank_d;
  logic [1:0]        used_q, used_d;

  logic              accept;
  logic              full;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] u;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  n;
  logic              sum_ok;
  logic              hit;
  logic [ENT_W-1:0]  hit_ent;

  assign s_axis_tready = (used_q < 2'(BANK_N));
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign b             = s_axis_tdata;
  assign u             = unescape(b);
  assign full          = (count_q == CNT_W'(BUF_DEPTH));
  assign cnt_m1        = count_q - CNT_W'(1);
  assign n             = count_q + CNT_W'(1);
  // sum of type..serial equals sum of all stored after the head minus the byte before the tail
  assign sum_ok        = !sum_en_q || ((sum_q - prev_q) == prev_q);

  // table match, highest entry wins
  always_comb begin
    hit     = 1'b0;
    hit_ent = '0;
    for (int e = 0; e < ENTRY_N; e++) begin
      if (type_q == entry_type_q[e] &&
          CMP_W'(n) == CMP_W'(entry_len_q[e]) + CMP_W'(FRAME_OVERHEAD)) begin
        hit     = 1'b1;
        hit_ent = ENT_W'(e);
      end
    end
  end

  // byte parser
  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    count_d    = count_q;
    sum_d      = sum_q;
    prev_d     = prev_q;
    type_d     = type_q;
    bank_d     = bank_q;
    mem_wr_o   = '0;
    push_o     = 1'b0;
    desc_o     = '0;
    if (accept) begin
      if (!in_frame_q || full) begin
        // hunting, or restart on a full buffer
        count_d    = '0;
        in_frame_d = 1'b0;
        esc_d      = 1'b0;
        if (b == HEAD_BYTE) begin
          mem_wr_o.en   = 1'b1;
          mem_wr_o.addr = {bank_q, ADDR_W'(0)};
          mem_wr_o.data = b;
          count_d       = CNT_W'(1);
          in_frame_d    = 1'b1;
          sum_d         = '0;
          prev_d        = b;
        end
      end else if (b != TAIL_BYTE && esc_q && b != ESC_BYTE) begin
        // replace the pending escape byte in place
        mem_wr_o.en   = 1'b1;
        mem_wr_o.addr = {bank_q, cnt_m1[ADDR_W-1:0]};
        mem_wr_o.data = u;
        sum_d         = sum_q - prev_q + u;
        prev_d        = u;
        esc_d         = 1'b0;
        if (cnt_m1 == CNT_W'(1)) begin
          type_d = u;
        end
      end else begin
        // plain store, escape byte or tail
        mem_wr_o.en   = 1'b1;
        mem_wr_o.addr = {bank_q, count_q[ADDR_W-1:0]};
        mem_wr_o.data = b;
        count_d       = n;
        sum_d         = sum_q + b;
        prev_d        = b;
        if (count_q == CNT_W'(1)) begin
          type_d = b;
        end
        if (b == ESC_BYTE) begin
          esc_d = 1'b1;
        end
        if (b == TAIL_BYTE) begin
          count_d    = '0;
          in_frame_d = 1'b0;
          esc_d      = 1'b0;
          if (sum_ok && hit) begin
            push_o       = 1'b1;
            desc_o.bank  = bank_q;
            desc_o.len   = n;
            desc_o.entry = hit_ent;
            bank_d       = ~bank_q;
          end
        end
      end
    end
  end

  // banks held by queued or emitting frames
  always_comb begin
    used_d = used_q;
    if (push_o && !release_i) begin
      used_d = used_q + 2'd1;
    end else if (!push_o && release_i) begin
      used_d = used_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      count_q    <= '0;
      sum_q      <= '0;
      prev_q     <= '0;
      type_q     <= '0;
      bank_q     <= 1'b0;
      used_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      prev_q     <= prev_d;
      type_q     <= type_d;
      bank_q     <= bank_d;
      used_q     <= used_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < ENTRY_N; e++) begin
        entry_type_q[e] <= '0;
        entry_len_q[e]  <= '0;
      end
      sum_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_E0_TYPE: entry_type_q[0] <= cfg_data_i;
        REG_E0_LEN:  entry_len_q[0]  <= cfg_data_i[LEN_W-1:0];
        REG_E1_TYPE: entry_type_q[1] <= cfg_data_i;
        REG_E1_LEN:  entry_len_q[1]  <= cfg_data_i[LEN_W-1:0];
        REG_E2_TYPE: entry_type_q[2] <= cfg_data_i;
        REG_E2_LEN:  entry_len_q[2]  <= cfg_data_i[LEN_W-1:0];
        REG_SUM_EN:  sum_en_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // bank credit never exceeds the number of banks
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= 2'(BANK_N))
    else $error("bank credit overflow");

  // a frame is handed over only while a bank is free
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (used_q < 2'(BANK_N)) && accept && (b == TAIL_BYTE))
    else $error("frame pushed without a free bank");

  // fill count stays within the buffer and is zero while hunting
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(BUF_DEPTH) && (in_frame_q || count_q == '0))
    else $error("fill count out of range");

endmodule

FILE: src/sfr_queue.sv
module sfr_queue
  import sfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  frame_desc_t desc_i,
  input  logic        pop_i,
  output logic        valid_o,
  output frame_desc_t desc_o
);

  frame_desc_t slot_q [BANK_N];
  logic        wptr_q, rptr_q;
  logic [1:0]  fill_q;

  assign valid_o = (fill_q != 2'd0);
  assign desc_o  = slot_q[rptr_q];

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= desc_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (!push_i && pop_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

FILE: src/sfr_back.sv
module sfr_back
  import sfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mem_wr_t             mem_wr_i,
  input  logic                q_valid_i,
  input  frame_desc_t         q_desc_i,
  output logic                pop_o,
  output logic                release_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // frame_byte[7:0], byte_pos[13:8], entry_index[15:14]
  output logic                m_axis_tlast
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_OUT  = 3'b100
  } bk_state_e;

  bk_state_e         state_q, state_d;
  frame_desc_t       desc_q, desc_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [BYTE_W-1:0] rd_data_q;
  logic [BYTE_W-1:0] frame_mem [BANK_N*BUF_DEPTH];
  logic              rd_en;
  logic              is_last;

  // two-bank frame buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      frame_mem[mem_wr_i.addr] <= mem_wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= frame_mem[{desc_q.bank, idx_q}];
    end
  end

  assign is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == desc_q.len);

  // output fields
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {desc_q.entry, POS_W'(idx_q), rd_data_q};
  assign m_axis_tlast  = is_last;

  // emit sequencer
  always_comb begin
    state_d   = state_q;
    desc_d    = desc_q;
    idx_d     = idx_q;
    pop_o     = 1'b0;
    release_o = 1'b0;
    rd_en     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          desc_d  = q_desc_i;
          idx_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) begin
          if (is_last) begin
            release_o = 1'b1;
            state_d   = S_IDLE;
          end else begin
            idx_d   = idx_q + ADDR_W'(1);
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  // a descriptor is taken only by an idle sequencer
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == S_IDLE) && q_valid_i)
    else $error("descriptor taken while busy");

  // emitted position stays inside the frame
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (CNT_W'(idx_q) < desc_q.len))
    else $error("byte position beyond frame length");

  // a read always precedes each presented byte
  a_read_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_RD))
    else $error("byte presented without a buffer read");

endmodule

FILE: src/stuffed_frame_receiver.sv
// Byte-stuffed frame receiver.
// Raw line bytes enter on the s_axis channel, one item per byte. The front
// end hunts for the head byte, stores the frame body into one bank of a
// two-bank buffer, undoes escapes in place and keeps a running sum, so the
// frame is checked and matched against the three table entries in the
// cycle the tail arrives. Matching frames queue for the back end, which
// reads them out of the buffer and emits one item per byte on m_axis, head
// through tail, with tlast on the tail. Other frames leave no output.
// Input side: one byte per cycle while a buffer bank is free; s_axis_tready
// drops only when both banks hold frames not yet fully emitted.
// Output side: each byte takes a buffer read (S_RD) and then the output
// register (S_OUT), and the next read starts only after the byte is taken;
// with the back end idle the first byte follows the tail through the queue,
// the idle-state pop and the buffer read.
// A stall on m_axis holds the current byte; the front end keeps receiving
// into the free bank meanwhile.
// Reset clears the table, disables the sum check and returns to hunting;
// the buffer needs no clearing. Configuration must be written on the cfg
// port only while no frame is pending; the block does not enforce it.
module stuffed_frame_receiver
  import sfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // frame_byte[7:0], byte_pos[13:8], entry_index[15:14]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  mem_wr_t     mem_wr;
  logic        push;
  frame_desc_t push_desc;
  logic        q_valid;
  frame_desc_t q_desc;
  logic        pop;
  logic        rel;

  // receive, unescape and classify
  sfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .release_i    (rel),
    .mem_wr_o     (mem_wr),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  // accepted frames waiting for emission
  sfr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (push_desc),
    .pop_i  (pop),
    .valid_o(q_valid),
    .desc_o (q_desc)
  );

  // buffer and byte emitter
  sfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mem_wr_i     (mem_wr),
    .q_valid_i    (q_valid),
    .q_desc_i     (q_desc),
    .pop_o        (pop),
    .release_o    (rel),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

FILE: tb/sv/stuffed_frame_receiver_tb.sv
module stuffed_frame_receiver_tb;
  import sfr_pkg::*;

  localparam int          CLK_PERIOD   = 4;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          DRAIN_CYCLES = 2 * BUF_DEPTH + 8;
  localparam int          LONG_HOLD    = 300;
  localparam int          N_PHASES     = 5;
  localparam int          PREDICTED    = -1;
  localparam logic [2:0]  REG_SPARE    = 3'd7;

  // one output item: the unescaped byte and its place in the frame
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [ENT_W-1:0]  entry;
    logic              last;
  } frame_item_t;

  // directed row: line byte, typed result count (or predicted) and entry
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    int                typed_n;
    logic [ENT_W-1:0]  typed_ent;
  } dir_row_t;

  typedef enum int {FK_GOOD, FK_ALIEN, FK_BADSUM, FK_RAWSPECIAL, FK_NOISE, FK_OVERLONG}
    frame_kind_e;
  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_PERIODIC} rdy_mode_e;
  typedef enum int {PH_RANDOM, PH_TIE_SUM, PH_LONGEST, PH_SHORTEST, PH_MIXED} phase_e;

  // after reset every entry is type 0 with no payload, so entry 2 wins
  localparam dir_row_t DIR_ROWS [25] = '{
    '{8'h00,     PREDICTED, 2'd0},   // noise while hunting
    '{HEAD_BYTE, PREDICTED, 2'd0},
    '{8'h00,     PREDICTED, 2'd0},
    '{8'hFF,     PREDICTED, 2'd0},
    '{8'h22,     PREDICTED, 2'd0},
    '{TAIL_BYTE, 5,         2'd2},
    '{HEAD_BYTE, PREDICTED, 2'd0},   // head and tail only, never matches
    '{TAIL_BYTE, 0,         2'd0},
    '{HEAD_BYTE, PREDICTED, 2'd0},   // repeated escape, only the last one replaced
    '{8'h00,     PREDICTED, 2'd0},
    '{ESC_BYTE,  PREDICTED, 2'd0},
    '{ESC_BYTE,  PREDICTED, 2'd0},
    '{ESC_TAIL,  PREDICTED, 2'd0},
    '{TAIL_BYTE, PREDICTED, 2'd0},
    '{HEAD_BYTE, PREDICTED, 2'd0},   // tail closes the frame with an escape pending
    '{8'h00,     PREDICTED, 2'd0},
    '{ESC_BYTE,  PREDICTED, 2'd0},
    '{ESC_HEAD,  PREDICTED, 2'd0},
    '{ESC_BYTE,  PREDICTED, 2'd0},
    '{TAIL_BYTE, PREDICTED, 2'd0},
    '{HEAD_BYTE, PREDICTED, 2'd0},   // raw head inside a frame is plain data
    '{8'h00,     PREDICTED, 2'd0},
    '{HEAD_BYTE, PREDICTED, 2'd0},
    '{ESC_ESC,   PREDICTED, 2'd0},
    '{TAIL_BYTE, 5,         2'd2}
  };

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = 8'h00;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;
  logic               m_axis_tlast;
  logic               cfg_we_i      = 1'b0;
  logic [2:0]         cfg_idx_i     = 3'd0;
  logic [7:0]         cfg_data_i    = 8'h00;

  // deframer mirror: table, sum switch and receive state
  logic [BYTE_W-1:0]  tbl_type [ENTRY_N];
  logic [LEN_W-1:0]   tbl_len  [ENTRY_N];
  logic               sum_on;
  logic [BYTE_W-1:0]  rx_store [BUF_DEPTH];
  int unsigned        rx_count;
  logic               rx_open;
  logic               rx_esc;

  frame_item_t        fresh_items [$];
  frame_item_t        frame_items_due [$];
  logic [BYTE_W-1:0]  line_hist [$];
  int unsigned        err_cnt;
  int unsigned        bytes_sent;
  int unsigned        burst_left;
  logic               hold_req;

  stuffed_frame_receiver i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // rx_byte[7:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // frame_byte[7:0], byte_pos[13:8], entry_index[15:14]
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // back to hunting with an empty store
  function automatic void drop_frame();
    rx_count = 0;
    rx_open  = 1'b0;
    rx_esc   = 1'b0;
    foreach (rx_store[i]) rx_store[i] = '0;
  endfunction

  // one line byte into the mirror, a finished frame that passes the sum and table lands in fresh_items
  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    int unsigned       n;
    logic [BYTE_W-1:0] acc;
    int                hit;
    hit = -1;
    fresh_items.delete();
    if (rx_count >= BUF_DEPTH) drop_frame();
    rx_store[rx_count] = b;
    rx_count++;
    if (!rx_open) begin
      if (b == HEAD_BYTE) rx_open = 1'b1;
      else drop_frame();
      return;
    end
    if (b == ESC_BYTE) begin
      rx_esc = 1'b1;
      return;
    end
    if (b != TAIL_BYTE) begin
      // escaped byte overwrites the escape it follows
      if (rx_esc) begin
        rx_count--;
        case (b)
          ESC_HEAD: rx_store[rx_count-1] = HEAD_BYTE;
          ESC_TAIL: rx_store[rx_count-1] = TAIL_BYTE;
          ESC_ESC:  rx_store[rx_count-1] = ESC_BYTE;
          default:  rx_store[rx_count-1] = b;
        endcase
        rx_esc = 1'b0;
      end
      return;
    end
    n = rx_count;
    // sum of type, payload and serial against the byte before the tail
    if (sum_on) begin
      acc = '0;
      for (int unsigned i = 1; i + 2 < n; i++) acc += rx_store[i];
      if (acc != rx_store[n-2]) begin
        drop_frame();
        return;
      end
    end
    for (int e = 0; e < ENTRY_N; e++)
      if (rx_store[1] == tbl_type[e] && n == tbl_len[e] + FRAME_OVERHEAD) hit = e;
    if (hit >= 0)
      for (int unsigned i = 0; i < n; i++)
        fresh_items.push_back('{data: rx_store[i], pos: POS_W'(i), entry: ENT_W'(hit),
                                last: (i + 1 == n)});
    drop_frame();
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  // line byte generator biased toward framing codes and extremes
  function automatic logic [BYTE_W-1:0] pick_byte();
    logic [BYTE_W-1:0] r;
    r = BYTE_W'($urandom);
    if ($urandom_range(0, 3) == 0)
      case ($urandom_range(0, 7))
        0:       r = HEAD_BYTE;
        1:       r = TAIL_BYTE;
        2:       r = ESC_BYTE;
        3:       r = ESC_HEAD;
        4:       r = ESC_TAIL;
        5:       r = ESC_ESC;
        6:       r = 8'h00;
        default: r = 8'hFF;
      endcase
    return r;
  endfunction

  // offer one byte in bursts with gaps, then predict once it is taken
  task automatic send_byte(input logic [BYTE_W-1:0] b, input int typed_n,
                           input logic [ENT_W-1:0] typed_ent);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    line_hist.push_back(b);
    if (line_hist.size() > BUF_DEPTH) void'(line_hist.pop_front());
    deframe_byte(b);
    if (typed_n == PREDICTED) begin
      foreach (fresh_items[j]) frame_items_due.push_back(fresh_items[j]);
    end else begin
      // typed frames carry no escapes, so the line bytes are the frame
      for (int k = 0; k < typed_n; k++)
        frame_items_due.push_back('{data: line_hist[line_hist.size() - typed_n + k],
                                    pos: POS_W'(k), entry: typed_ent,
                                    last: (k == typed_n - 1)});
    end
  endtask

  // one frame, well formed or broken according to kind
  task automatic send_frame(input frame_kind_e kind);
    logic [BYTE_W-1:0] body [$];
    logic [BYTE_W-1:0] cks;
    logic [BYTE_W-1:0] bv;
    int unsigned       e;
    int unsigned       plen;
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 6)) send_byte(pick_byte(), PREDICTED, '0);
      return;
    end
    if (kind == FK_OVERLONG) begin
      // overfill the buffer so the open frame fills the store and is dropped
      send_byte(HEAD_BYTE, PREDICTED, '0);
      repeat ($urandom_range(62, 66)) begin
        do bv = BYTE_W'($urandom); while (bv == TAIL_BYTE || bv == ESC_BYTE);
        send_byte(bv, PREDICTED, '0);
      end
    end else if (rx_open) begin
      // close whatever is open so this frame starts from hunting
      send_byte(TAIL_BYTE, PREDICTED, '0);
    end
    e = $urandom_range(0, ENTRY_N - 1);
    if (kind == FK_ALIEN) begin
      body.push_back(BYTE_W'($urandom));
      plen = $urandom_range(0, 8);
    end else begin
      body.push_back(tbl_type[e]);
      plen = tbl_len[e];
    end
    repeat (plen) body.push_back(pick_byte());
    body.push_back(BYTE_W'($urandom));
    cks = '0;
    foreach (body[i]) cks += body[i];
    if (kind == FK_BADSUM) cks += BYTE_W'($urandom_range(1, 255));
    body.push_back(cks);
    send_byte(HEAD_BYTE, PREDICTED, '0);
    foreach (body[i]) begin
      bv = body[i];
      if (bv == HEAD_BYTE || bv == TAIL_BYTE || bv == ESC_BYTE) begin
        if (kind == FK_RAWSPECIAL && $urandom_range(0, 1) == 1) begin
          send_byte(bv, PREDICTED, '0);
        end else begin
          send_byte(ESC_BYTE, PREDICTED, '0);
          send_byte(bv == HEAD_BYTE ? ESC_HEAD : bv == TAIL_BYTE ? ESC_TAIL : ESC_ESC,
                    PREDICTED, '0);
        end
      end else begin
        // needless escape before a plain byte leaves it as it is
        if (bv != ESC_HEAD && bv != ESC_TAIL && bv != ESC_ESC && $urandom_range(0, 15) == 0)
          send_byte(ESC_BYTE, PREDICTED, '0);
        send_byte(bv, PREDICTED, '0);
      end
    end
    send_byte(TAIL_BYTE, PREDICTED, '0);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [BYTE_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_E0_TYPE: tbl_type[0] = val;
      REG_E0_LEN:  tbl_len[0]  = val[LEN_W-1:0];
      REG_E1_TYPE: tbl_type[1] = val;
      REG_E1_LEN:  tbl_len[1]  = val[LEN_W-1:0];
      REG_E2_TYPE: tbl_type[2] = val;
      REG_E2_LEN:  tbl_len[2]  = val[LEN_W-1:0];
      REG_SUM_EN:  sum_on      = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // table and sum switch for one phase
  task automatic load_phase(input phase_e ph);
    logic [BYTE_W-1:0] ty [ENTRY_N];
    logic [LEN_W-1:0]  ln [ENTRY_N];
    logic              se;
    for (int i = 0; i < ENTRY_N; i++) begin
      ty[i] = BYTE_W'($urandom);
      ln[i] = LEN_W'($urandom_range(0, 6));
    end
    se = 1'($urandom_range(0, 1));
    case (ph)
      PH_RANDOM: se = 1'b0;
      PH_TIE_SUM: begin
        ty[1] = ty[0];
        ln[1] = ln[0];
        ty[2] = 8'hFF;
        ln[2] = '0;
        se    = 1'b1;
      end
      PH_LONGEST: begin
        for (int i = 0; i < ENTRY_N; i++) begin
          ty[i] = 8'hFF;
          ln[i] = LEN_W'(BUF_DEPTH - FRAME_OVERHEAD);
        end
        se = 1'b1;
      end
      PH_SHORTEST: begin
        ty[0] = 8'h00;
        ty[1] = 8'h7F;
        ty[2] = 8'h80;
        for (int i = 0; i < ENTRY_N; i++) ln[i] = '0;
      end
      default: ;
    endcase
    write_cfg(REG_E0_TYPE, ty[0]);
    write_cfg(REG_E0_LEN,  BYTE_W'(ln[0]));
    write_cfg(REG_E1_TYPE, ty[1]);
    write_cfg(REG_E1_LEN,  BYTE_W'(ln[1]));
    write_cfg(REG_E2_TYPE, ty[2]);
    write_cfg(REG_E2_LEN,  BYTE_W'(ln[2]));
    write_cfg(REG_SUM_EN,  BYTE_W'(se));
    // an index with no register behind it must change nothing
    if (ph == PH_MIXED) write_cfg(REG_SPARE, BYTE_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (frame_items_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic frame_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r <= 10) return FK_GOOD;
    if (r <= 12) return FK_ALIEN;
    if (r <= 14) return FK_BADSUM;
    if (r <= 16) return FK_RAWSPECIAL;
    if (r <= 18) return FK_NOISE;
    return FK_OVERLONG;
  endfunction

  // output side check against the oldest predicted item
  always @(posedge clk_i) begin : out_check
    frame_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frame_items_due.size() == 0) begin
        $display("%0t: unexpected item, expected none, got data %0h last %0b",
                 $time, m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        want = frame_items_due.pop_front();
        check_field("frame_byte", want.data, m_axis_tdata[BYTE_W-1:0]);
        check_field("byte_pos", want.pos, m_axis_tdata[BYTE_W+POS_W-1:BYTE_W]);
        check_field("entry_index", want.entry,
                    m_axis_tdata[BYTE_W+POS_W+ENT_W-1:BYTE_W+POS_W]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  // receiver pacing, with one long hold to back the block up
  initial begin : out_pace
    rdy_mode_e   mode;
    int unsigned span;
    int unsigned tick;
    logic        hold_done;
    mode      = RDY_ALWAYS;
    span      = 0;
    tick      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if (span == 0) begin
        mode = rdy_mode_e'($urandom_range(0, 3));
        span = $urandom_range(8, 64);
      end
      span--;
      case (mode)
        RDY_ALWAYS:  m_axis_tready <= 1'b1;
        RDY_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
        RDY_MOSTLY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
        default:     m_axis_tready <= (tick % 3 == 0);
      endcase
    end
  end

  initial begin : run_limit
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("stuffed_frame_receiver_tb: done, errors");
    $finish;
  end

  initial begin : main
    phase_e      ph;
    int unsigned phase_start;
    int unsigned frames;
    int unsigned budget;
    err_cnt    = 0;
    bytes_sent = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    sum_on     = 1'b0;
    for (int i = 0; i < ENTRY_N; i++) begin
      tbl_type[i] = '0;
      tbl_len[i]  = '0;
    end
    drop_frame();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under the reset table
    for (int r = 0; r < $size(DIR_ROWS); r++)
      send_byte(DIR_ROWS[r].rx, DIR_ROWS[r].typed_n, DIR_ROWS[r].typed_ent);
    s_axis_tvalid <= 1'b0;
    wait_idle();

    // random frames, one table setting per phase
    for (int p = 0; p < N_PHASES; p++) begin
      ph = phase_e'(p);
      load_phase(ph);
      if (ph == PH_RANDOM) hold_req = 1'b1;
      budget      = (ph == PH_RANDOM) ? 60 : 20;
      phase_start = bytes_sent;
      frames      = 0;
      while (bytes_sent - phase_start < budget || frames < 1) begin
        send_frame(pick_kind());
        frames++;
      end
      s_axis_tvalid <= 1'b0;
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("stuffed_frame_receiver_tb: done, clean");
    end else begin
      $display("stuffed_frame_receiver_tb: done, errors");
    end
    $finish;
  end

endmodule
